// File: sv/pocl_pkg.sv
// Package for the pair offset closure table: sizes, field positions, codes,
// controller/datapath command and status structs, and the offset clip function.
// Used by every module of the block but pocl_ram; depends on nothing.
`default_nettype none

package pocl_pkg;

    // Table geometry and number formats.
    localparam int MAX_IMAGES = 64;
    localparam int OFS_W      = 20;
    localparam int IN_W       = 20;
    localparam int FRAC_BITS  = 4;
    localparam int IDX_W      = $clog2(MAX_IMAGES);
    localparam int CNT_W      = 7;
    localparam int DIM_W      = 13;
    localparam int LOOP_W     = ((IDX_W + 1) > CNT_W) ? (IDX_W + 1) : CNT_W;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int TBL_DEPTH  = 1 << ADDR_W;
    localparam int ROW_DEPTH  = 1 << IDX_W;
    localparam int ENT_W      = 2 * OFS_W;
    localparam int CLIP_W     = ((IN_W > OFS_W) ? IN_W : OFS_W) + 2;
    localparam int MAG_W      = OFS_W + 1;
    localparam int CMP_W      = (MAG_W > (DIM_W + FRAC_BITS)) ? MAG_W : (DIM_W + FRAC_BITS);

    // Stream and configuration port widths.
    localparam int FIELD_IDX_W = 6;
    localparam int KIND_W      = 2;
    localparam int S_DATA_W    = 56;
    localparam int M_DATA_W    = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 13;

    // Input word field positions.
    localparam int RI_LSB  = 0;
    localparam int TI_LSB  = RI_LSB + FIELD_IDX_W;
    localparam int ACC_BIT = TI_LSB + FIELD_IDX_W;
    localparam int OX_LSB  = ACC_BIT + 1;
    localparam int OY_LSB  = OX_LSB + IN_W;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_COUNT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // Configuration reset values.
    localparam logic [CNT_W-1:0] RST_IMAGE_COUNT = 7'd64;
    localparam logic [DIM_W-1:0] RST_IMAGE_DIM   = 13'd512;

    // Saturation bounds of a stored offset.
    localparam logic signed [CLIP_W-1:0] OFS_MAX_W =
        (CLIP_W'(1) <<< (OFS_W - 1)) - CLIP_W'(1);
    localparam logic signed [CLIP_W-1:0] OFS_MIN_W = -OFS_MAX_W - CLIP_W'(1);

    typedef enum logic [KIND_W-1:0] {
        KIND_CHECK = 2'd0,
        KIND_LINK  = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    // Table write selections.
    typedef enum logic [2:0] {
        WR_NONE,
        WR_ZERO,
        WR_DIRECT,
        WR_DIRECT_NEG,
        WR_SUM,
        WR_SUM_NEG
    } t_wr;

    // Table read address selections.
    typedef enum logic [1:0] {
        RD_PAIR,
        RD_COL,
        RD_ROW
    } t_rd;

    typedef struct packed {
        logic              accept;
        logic              tbl_rd_en;
        t_rd               tbl_rd_sel;
        t_wr               wr;
        logic [ADDR_W-1:0] clr_addr;
        logic [LOOP_W-1:0] a;
        logic [LOOP_W-1:0] b;
        logic              col_wr;
        logic              row_wr;
        logic              col_rd_en;
        logic              row_rd_en;
        logic [LOOP_W-1:0] row_rd_idx;
        logic              set_ok;
        logic              set_linked;
        logic              load_out;
    } t_cmd;

    typedef struct packed {
        t_kind             kind;
        logic              link_go;
        logic              g1;
        logic              pair_active;
        logic              out_busy;
        logic [LOOP_W-1:0] n;
    } t_sts;

    typedef struct packed {
        logic signed [OFS_W-1:0] val;
        logic                    sat;
    } t_clip;

    // Clip a wide signed value into the stored offset range.
    function automatic t_clip clip_ofs(input logic signed [CLIP_W-1:0] v);
        t_clip r;
        if (v > OFS_MAX_W) begin
            r.val = OFS_MAX_W[OFS_W-1:0];
            r.sat = 1'b1;
        end else if (v < OFS_MIN_W) begin
            r.val = OFS_MIN_W[OFS_W-1:0];
            r.sat = 1'b1;
        end else begin
            r.val = v[OFS_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/pocl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the offset table and the column and row snapshots; no dependencies.
`default_nettype none

module pocl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/pocl_dp.sv
// Datapath of the pair offset closure table: configuration registers, item and
// result registers, offset table and snapshot RAMs, saturating adders.
// Depends on pocl_pkg and pocl_ram.
`default_nettype none

module pocl_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [pocl_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [pocl_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire logic [pocl_pkg::S_DATA_W-1:0]      i_s_tdata,
    input  wire logic [pocl_pkg::KIND_W-1:0]        i_s_tuser,
    input  wire logic                               i_m_tready,
    output logic                                    o_m_tvalid,
    output logic      [pocl_pkg::M_DATA_W-1:0]      o_m_tdata,
    input  wire pocl_pkg::t_cmd                     i_cmd,
    output pocl_pkg::t_sts                          o_sts
);

    // Configuration registers.
    logic [pocl_pkg::CNT_W-1:0] r_cfg_count;
    logic [pocl_pkg::DIM_W-1:0] r_cfg_width;
    logic [pocl_pkg::DIM_W-1:0] r_cfg_height;

    // Captured item.
    logic [pocl_pkg::KIND_W-1:0]      r_kind;
    logic [pocl_pkg::FIELD_IDX_W-1:0] r_ri;
    logic [pocl_pkg::FIELD_IDX_W-1:0] r_ti;
    logic                             r_acc;
    logic signed [pocl_pkg::IN_W-1:0] r_ox;
    logic signed [pocl_pkg::IN_W-1:0] r_oy;

    // Result flags and output stage.
    logic                           r_res_ok;
    logic                           r_res_linked;
    logic                           r_res_sat;
    logic                           r_out_valid;
    logic [pocl_pkg::M_DATA_W-1:0]  r_out_data;

    // Latched closure sum for the transposed write.
    logic signed [pocl_pkg::OFS_W-1:0] r_sx;
    logic signed [pocl_pkg::OFS_W-1:0] r_sy;

    logic [pocl_pkg::LOOP_W-1:0] eff_count;
    logic [pocl_pkg::LOOP_W-1:0] ri_ext;
    logic [pocl_pkg::LOOP_W-1:0] ti_ext;
    logic [pocl_pkg::IDX_W-1:0]  ri_a;
    logic [pocl_pkg::IDX_W-1:0]  ti_a;
    logic [pocl_pkg::IDX_W-1:0]  a_a;
    logic [pocl_pkg::IDX_W-1:0]  b_a;

    logic [pocl_pkg::ENT_W-1:0]  tbl_q;
    logic [pocl_pkg::ENT_W-1:0]  col_q;
    logic [pocl_pkg::ENT_W-1:0]  row_q;
    logic                        tbl_we;
    logic [pocl_pkg::ADDR_W-1:0] tbl_waddr;
    logic [pocl_pkg::ENT_W-1:0]  tbl_wdata;
    logic                        wr_sat;
    logic [pocl_pkg::ADDR_W-1:0] tbl_raddr;

    pocl_pkg::t_clip dx_clip;
    pocl_pkg::t_clip dy_clip;
    pocl_pkg::t_clip dxn_clip;
    pocl_pkg::t_clip dyn_clip;
    pocl_pkg::t_clip sum_x;
    pocl_pkg::t_clip sum_y;
    pocl_pkg::t_clip sxn_clip;
    pocl_pkg::t_clip syn_clip;

    logic signed [pocl_pkg::OFS_W-1:0] dx_c;
    logic signed [pocl_pkg::OFS_W-1:0] dy_c;
    logic signed [pocl_pkg::OFS_W-1:0] col_x;
    logic signed [pocl_pkg::OFS_W-1:0] col_y;
    logic signed [pocl_pkg::OFS_W-1:0] row_x;
    logic signed [pocl_pkg::OFS_W-1:0] row_y;
    logic signed [pocl_pkg::OFS_W-1:0] tbl_x;
    logic signed [pocl_pkg::OFS_W-1:0] tbl_y;
    logic signed [pocl_pkg::MAG_W-1:0] x_ext;
    logic signed [pocl_pkg::MAG_W-1:0] y_ext;
    logic [pocl_pkg::MAG_W-1:0]        mag_x;
    logic [pocl_pkg::MAG_W-1:0]        mag_y;
    logic [pocl_pkg::CMP_W-1:0]        bound_x;
    logic [pocl_pkg::CMP_W-1:0]        bound_y;
    logic                              idx_ok;
    logic                              ok_now;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count  <= pocl_pkg::RST_IMAGE_COUNT;
            r_cfg_width  <= pocl_pkg::RST_IMAGE_DIM;
            r_cfg_height <= pocl_pkg::RST_IMAGE_DIM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pocl_pkg::CFG_IMAGE_COUNT:  r_cfg_count  <= i_cfg_wdata[pocl_pkg::CNT_W-1:0];
                pocl_pkg::CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_wdata;
                pocl_pkg::CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective image count and index forms.
    assign eff_count = (pocl_pkg::LOOP_W'(r_cfg_count) > pocl_pkg::LOOP_W'(pocl_pkg::MAX_IMAGES))
                       ? pocl_pkg::LOOP_W'(pocl_pkg::MAX_IMAGES)
                       : pocl_pkg::LOOP_W'(r_cfg_count);
    assign ri_ext = pocl_pkg::LOOP_W'(r_ri);
    assign ti_ext = pocl_pkg::LOOP_W'(r_ti);
    assign ri_a   = ri_ext[pocl_pkg::IDX_W-1:0];
    assign ti_a   = ti_ext[pocl_pkg::IDX_W-1:0];
    assign a_a    = i_cmd.a[pocl_pkg::IDX_W-1:0];
    assign b_a    = i_cmd.b[pocl_pkg::IDX_W-1:0];

    // Item capture on the accepting edge.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_s_tuser;
            r_ri   <= i_s_tdata[pocl_pkg::RI_LSB +: pocl_pkg::FIELD_IDX_W];
            r_ti   <= i_s_tdata[pocl_pkg::TI_LSB +: pocl_pkg::FIELD_IDX_W];
            r_acc  <= i_s_tdata[pocl_pkg::ACC_BIT];
            r_ox   <= i_s_tdata[pocl_pkg::OX_LSB +: pocl_pkg::IN_W];
            r_oy   <= i_s_tdata[pocl_pkg::OY_LSB +: pocl_pkg::IN_W];
        end
    end

    // Clipped direct offset, its negation, closure sum and its negation.
    always_comb begin
        dx_clip  = pocl_pkg::clip_ofs(pocl_pkg::CLIP_W'(r_ox));
        dy_clip  = pocl_pkg::clip_ofs(pocl_pkg::CLIP_W'(r_oy));
        dx_c     = dx_clip.val;
        dy_c     = dy_clip.val;
        dxn_clip = pocl_pkg::clip_ofs(-pocl_pkg::CLIP_W'(dx_c));
        dyn_clip = pocl_pkg::clip_ofs(-pocl_pkg::CLIP_W'(dy_c));
        col_x    = col_q[pocl_pkg::OFS_W-1:0];
        col_y    = col_q[pocl_pkg::ENT_W-1:pocl_pkg::OFS_W];
        row_x    = row_q[pocl_pkg::OFS_W-1:0];
        row_y    = row_q[pocl_pkg::ENT_W-1:pocl_pkg::OFS_W];
        sum_x    = pocl_pkg::clip_ofs(pocl_pkg::CLIP_W'(col_x) + pocl_pkg::CLIP_W'(dx_c)
                                      + pocl_pkg::CLIP_W'(row_x));
        sum_y    = pocl_pkg::clip_ofs(pocl_pkg::CLIP_W'(col_y) + pocl_pkg::CLIP_W'(dy_c)
                                      + pocl_pkg::CLIP_W'(row_y));
        sxn_clip = pocl_pkg::clip_ofs(-pocl_pkg::CLIP_W'(r_sx));
        syn_clip = pocl_pkg::clip_ofs(-pocl_pkg::CLIP_W'(r_sy));
    end

    // Keep the closure sum for the mirrored entry.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr == pocl_pkg::WR_SUM) begin
            r_sx <= sum_x.val;
            r_sy <= sum_y.val;
        end
    end

    // Table write address and data; y sits above x in a word.
    always_comb begin
        tbl_we    = 1'b1;
        tbl_waddr = '0;
        tbl_wdata = '0;
        wr_sat    = 1'b0;
        unique case (i_cmd.wr)
            pocl_pkg::WR_NONE: begin
                tbl_we = 1'b0;
            end
            pocl_pkg::WR_ZERO: begin
                tbl_waddr = i_cmd.clr_addr;
            end
            pocl_pkg::WR_DIRECT: begin
                tbl_waddr = {ri_a, ti_a};
                tbl_wdata = {dy_c, dx_c};
                wr_sat    = dx_clip.sat | dy_clip.sat;
            end
            pocl_pkg::WR_DIRECT_NEG: begin
                tbl_waddr = {ti_a, ri_a};
                tbl_wdata = {dyn_clip.val, dxn_clip.val};
                wr_sat    = dxn_clip.sat | dyn_clip.sat;
            end
            pocl_pkg::WR_SUM: begin
                tbl_waddr = {a_a, b_a};
                tbl_wdata = {sum_y.val, sum_x.val};
                wr_sat    = sum_x.sat | sum_y.sat;
            end
            pocl_pkg::WR_SUM_NEG: begin
                tbl_waddr = {b_a, a_a};
                tbl_wdata = {syn_clip.val, sxn_clip.val};
                wr_sat    = sxn_clip.sat | syn_clip.sat;
            end
            default: begin
                tbl_we = 1'b0;
            end
        endcase
    end

    // Table read address.
    always_comb begin
        unique case (i_cmd.tbl_rd_sel)
            pocl_pkg::RD_PAIR: tbl_raddr = {ri_a, ti_a};
            pocl_pkg::RD_COL:  tbl_raddr = {a_a, ri_a};
            pocl_pkg::RD_ROW:  tbl_raddr = {ti_a, a_a};
            default:           tbl_raddr = {ri_a, ti_a};
        endcase
    end

    // Offset table, x in the low half and y in the high half of each word.
    pocl_ram #(
        .WIDTH (pocl_pkg::ENT_W),
        .DEPTH (pocl_pkg::TBL_DEPTH)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (i_cmd.tbl_rd_en),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_q)
    );

    // Snapshot of the column of the reference image.
    pocl_ram #(
        .WIDTH (pocl_pkg::ENT_W),
        .DEPTH (pocl_pkg::ROW_DEPTH)
    ) u_col (
        .i_clk   (i_clk),
        .i_we    (i_cmd.col_wr),
        .i_waddr (a_a),
        .i_wdata (tbl_q),
        .i_re    (i_cmd.col_rd_en),
        .i_raddr (a_a),
        .o_rdata (col_q)
    );

    // Snapshot of the row of the template image.
    pocl_ram #(
        .WIDTH (pocl_pkg::ENT_W),
        .DEPTH (pocl_pkg::ROW_DEPTH)
    ) u_row (
        .i_clk   (i_clk),
        .i_we    (i_cmd.row_wr),
        .i_waddr (a_a),
        .i_wdata (tbl_q),
        .i_re    (i_cmd.row_rd_en),
        .i_raddr (i_cmd.row_rd_idx[pocl_pkg::IDX_W-1:0]),
        .o_rdata (row_q)
    );

    // Pair check: indices below the image count, both magnitudes below the image size in Q.4 pixels.
    always_comb begin
        tbl_x   = tbl_q[pocl_pkg::OFS_W-1:0];
        tbl_y   = tbl_q[pocl_pkg::ENT_W-1:pocl_pkg::OFS_W];
        x_ext   = pocl_pkg::MAG_W'(tbl_x);
        y_ext   = pocl_pkg::MAG_W'(tbl_y);
        mag_x   = (x_ext < 0) ? -x_ext : x_ext;
        mag_y   = (y_ext < 0) ? -y_ext : y_ext;
        bound_x = pocl_pkg::CMP_W'({r_cfg_width, {pocl_pkg::FRAC_BITS{1'b0}}});
        bound_y = pocl_pkg::CMP_W'({r_cfg_height, {pocl_pkg::FRAC_BITS{1'b0}}});
        idx_ok  = (ri_ext < eff_count) && (ti_ext < eff_count);
        ok_now  = idx_ok && (pocl_pkg::CMP_W'(mag_x) < bound_x)
                         && (pocl_pkg::CMP_W'(mag_y) < bound_y);
    end

    // Result flags, cleared when an item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_ok     <= 1'b0;
            r_res_linked <= 1'b0;
            r_res_sat    <= 1'b0;
        end else if (i_cmd.accept) begin
            r_res_ok     <= 1'b0;
            r_res_linked <= 1'b0;
            r_res_sat    <= 1'b0;
        end else begin
            if (i_cmd.set_ok) begin
                r_res_ok <= ok_now;
            end
            if (i_cmd.set_linked) begin
                r_res_linked <= 1'b1;
            end
            if (wr_sat) begin
                r_res_sat <= 1'b1;
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= pocl_pkg::M_DATA_W'({r_res_sat, r_res_linked, r_res_ok});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Status toward the controller.
    always_comb begin
        o_sts.kind        = pocl_pkg::t_kind'(r_kind);
        o_sts.link_go     = r_acc && idx_ok && (r_ri != r_ti) && (tbl_q == '0);
        o_sts.g1          = (i_cmd.a == ri_ext) || (col_q != '0);
        o_sts.pair_active = ((i_cmd.b == ti_ext) || (row_q != '0)) && (i_cmd.a != i_cmd.b);
        o_sts.out_busy    = r_out_valid && !i_m_tready;
        o_sts.n           = eff_count;
    end

endmodule

`default_nettype wire

// File: sv/pocl_ctrl.sv
// Controller of the pair offset closure table: sequences item decode, the
// table clearing sweep, direct writes, snapshot and closure scan. Uses pocl_pkg.
`default_nettype none

module pocl_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire pocl_pkg::t_sts i_sts,
    output pocl_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        ST_CLR_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_EVAL,
        ST_W_NEG,
        ST_S_COL,
        ST_S_ROW,
        ST_S_WR,
        ST_A_RD,
        ST_A_CHK,
        ST_B_CHK,
        ST_B_WR,
        ST_CLEAR,
        ST_DONE
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [pocl_pkg::LOOP_W-1:0] r_a;
    logic [pocl_pkg::LOOP_W-1:0] n_a;
    logic [pocl_pkg::LOOP_W-1:0] r_b;
    logic [pocl_pkg::LOOP_W-1:0] n_b;
    logic [pocl_pkg::ADDR_W-1:0] r_clr;
    logic [pocl_pkg::ADDR_W-1:0] n_clr;

    logic [pocl_pkg::LOOP_W-1:0] a_inc;
    logic [pocl_pkg::LOOP_W-1:0] b_inc;
    logic                        a_last;
    logic                        b_last;

    assign a_inc      = r_a + 1'b1;
    assign b_inc      = r_b + 1'b1;
    assign a_last     = a_inc >= i_sts.n;
    assign b_last     = b_inc >= i_sts.n;
    assign o_s_tready = (r_state == ST_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_clr   = r_clr;

        o_cmd            = '0;
        o_cmd.a          = r_a;
        o_cmd.b          = r_b;
        o_cmd.clr_addr   = r_clr;
        o_cmd.row_rd_idx = r_b;

        unique case (r_state)
            ST_CLR_INIT: begin
                o_cmd.wr = pocl_pkg::WR_ZERO;
                n_clr    = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_sts.kind)
                    pocl_pkg::KIND_CHECK, pocl_pkg::KIND_LINK: begin
                        o_cmd.tbl_rd_en  = 1'b1;
                        o_cmd.tbl_rd_sel = pocl_pkg::RD_PAIR;
                        n_state          = ST_EVAL;
                    end
                    pocl_pkg::KIND_CLEAR: begin
                        n_clr   = '0;
                        n_state = ST_CLEAR;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_EVAL: begin
                if (i_sts.kind == pocl_pkg::KIND_CHECK) begin
                    o_cmd.set_ok = 1'b1;
                    n_state      = ST_DONE;
                end else if (i_sts.link_go) begin
                    o_cmd.wr         = pocl_pkg::WR_DIRECT;
                    o_cmd.set_linked = 1'b1;
                    n_state          = ST_W_NEG;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_W_NEG: begin
                o_cmd.wr = pocl_pkg::WR_DIRECT_NEG;
                n_a      = '0;
                n_state  = ST_S_COL;
            end
            // Snapshot: column entry of image a, then row entry, then store.
            ST_S_COL: begin
                o_cmd.tbl_rd_en  = 1'b1;
                o_cmd.tbl_rd_sel = pocl_pkg::RD_COL;
                n_state          = ST_S_ROW;
            end
            ST_S_ROW: begin
                o_cmd.col_wr     = 1'b1;
                o_cmd.tbl_rd_en  = 1'b1;
                o_cmd.tbl_rd_sel = pocl_pkg::RD_ROW;
                n_state          = ST_S_WR;
            end
            ST_S_WR: begin
                o_cmd.row_wr = 1'b1;
                if (a_last) begin
                    n_a     = '0;
                    n_state = ST_A_RD;
                end else begin
                    n_a     = a_inc;
                    n_state = ST_S_COL;
                end
            end
            // Closure scan, outer loop over the reference group.
            ST_A_RD: begin
                o_cmd.col_rd_en = 1'b1;
                n_state         = ST_A_CHK;
            end
            ST_A_CHK: begin
                if (i_sts.g1) begin
                    o_cmd.row_rd_en  = 1'b1;
                    o_cmd.row_rd_idx = '0;
                    n_b              = '0;
                    n_state          = ST_B_CHK;
                end else if (a_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_a     = a_inc;
                    n_state = ST_A_RD;
                end
            end
            // Inner loop over the template group; a written pair passes through ST_B_CHK and ST_B_WR.
            ST_B_CHK, ST_B_WR: begin
                if (r_state == ST_B_CHK && i_sts.pair_active) begin
                    o_cmd.wr = pocl_pkg::WR_SUM;
                    n_state  = ST_B_WR;
                end else begin
                    if (r_state == ST_B_WR) begin
                        o_cmd.wr = pocl_pkg::WR_SUM_NEG;
                    end
                    if (!b_last) begin
                        o_cmd.row_rd_en  = 1'b1;
                        o_cmd.row_rd_idx = b_inc;
                        n_b              = b_inc;
                        n_state          = ST_B_CHK;
                    end else if (a_last) begin
                        n_state = ST_DONE;
                    end else begin
                        n_a     = a_inc;
                        n_state = ST_A_RD;
                    end
                end
            end
            ST_CLEAR: begin
                o_cmd.wr = pocl_pkg::WR_ZERO;
                n_clr    = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and loop counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR_INIT;
            r_a     <= '0;
            r_b     <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_a     <= n_a;
            r_b     <= n_b;
            r_clr   <= n_clr;
        end
    end

    // The table is never written while a new word may be taken.
    a_ready_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (o_cmd.wr == pocl_pkg::WR_NONE))
        else $error("table write while ready for input");

    // A result is loaded only into a free output stage.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !i_sts.out_busy)
        else $error("result loaded over a pending output word");

    // An accepted word is decoded on the next cycle.
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == ST_DECODE))
        else $error("accepted word not decoded");

    // The mirrored closure write always follows its direct write.
    a_mirror_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_B_WR) |-> $past(o_cmd.wr == pocl_pkg::WR_SUM))
        else $error("mirrored write without a preceding sum write");

endmodule

`default_nettype wire

// File: sv/pair_offset_closure_table.sv
// Pair offset closure table: after reset the block sweeps its 4096-entry offset
// table to zero and takes no word meanwhile. A check word takes one table read.
// A link word that is stored takes the two direct writes, a snapshot of the
// reference column and template row, then a scan over each image and, for each
// image of the reference group, over each image again with a mirrored write per
// written pair, all on the one table RAM with one read and one write port. A
// clear word sweeps the table. One word is in work at a time; the output register
// lets the next word enter while a result waits.
// Depends on pocl_pkg, pocl_ctrl, pocl_dp and pocl_ram.
`default_nettype none

module pair_offset_closure_table (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pocl_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [pocl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata from bit 0: ref_index[6], tmpl_index[6], accepted[1], offset_x[20],
    // offset_y[20], zero fill[3]
    input  wire logic [pocl_pkg::S_DATA_W-1:0]   i_s_tdata,
    // tuser: kind[2]
    input  wire logic [pocl_pkg::KIND_W-1:0]     i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // tdata from bit 0: pair_ok[1], linked[1], saturated[1], zero fill[5]
    output logic      [pocl_pkg::M_DATA_W-1:0]   o_m_tdata
);

    pocl_pkg::t_cmd cmd;
    pocl_pkg::t_sts sts;

    // Sequencer.
    pocl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Storage, arithmetic and output stage.
    pocl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire
